>>> sv/cvp_pkg.sv
// ----------------------------------------------------------------------------
// cvp_pkg
// Shared types and constants of the cascaded volume/pressure PI controller.
// ----------------------------------------------------------------------------
package cvp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_VOL_P   = 3'd0;
  localparam logic [2:0] REG_VOL_I   = 3'd1;
  localparam logic [2:0] REG_PRS_P   = 3'd2;
  localparam logic [2:0] REG_PRS_I   = 3'd3;
  localparam logic [2:0] REG_VOL_LIM = 3'd4;
  localparam logic [2:0] REG_PRS_LIM = 3'd5;
  localparam logic [2:0] REG_POS_LIM = 3'd6;
  localparam logic [2:0] REG_NEG_LIM = 3'd7;

  localparam int SumW  = 48;
  localparam int DivW  = 34;   // dividend width of the limit division
  localparam int QuoW  = 34;

  // datapath operations issued by the controller
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;  // latch item
  localparam logic [3:0] OP_VDIV     = 4'd2;  // volume error, start limit divide
  localparam logic [3:0] OP_VSUM     = 4'd3;  // volume sum update
  localparam logic [3:0] OP_VMUL     = 4'd4;  // volume products
  localparam logic [3:0] OP_VOUT     = 4'd5;  // volume output, pressure target
  localparam logic [3:0] OP_PDIVH    = 4'd6;  // start upper limit divide
  localparam logic [3:0] OP_PDIVL    = 4'd7;  // start lower limit divide
  localparam logic [3:0] OP_PSUM     = 4'd8;
  localparam logic [3:0] OP_PMUL     = 4'd9;
  localparam logic [3:0] OP_POUT     = 4'd10;
  localparam logic [3:0] OP_PTERR    = 4'd11; // pressure target and error
  localparam logic [3:0] OP_SAVEHI   = 4'd12; // keep upper quotient

  typedef struct packed {
    logic [3:0] op;
  } cvp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic vmode;
  } cvp_sts_t;

endpackage

>>> sv/cvp_div.sv
// ----------------------------------------------------------------------------
// cvp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvp_div
  import cvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DivW-1:0]  dividend,
  input  logic [15:0]      divisor,
  output logic             busy,
  output logic [QuoW-1:0]  quotient
);

  logic [DivW-1:0] q_r, q_nxt;
  logic [16:0]     rem_r, rem_nxt;
  logic [15:0]     dvs_r, dvs_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [16:0]     trial;

  assign trial = {rem_r[15:0], q_r[DivW-1]};

  // shift one dividend bit into the remainder per cycle
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; dvs_nxt = divisor;
      cnt_nxt = 6'(DivW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt = {q_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      busy_nxt = (cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

>>> sv/cvp_datapath.sv
// ----------------------------------------------------------------------------
// cvp_datapath
// Registers, error sums, products and clamps of both PI loops.
// ----------------------------------------------------------------------------
module cvp_datapath
  import cvp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cvp_cmd_t     cmd,
  output cvp_sts_t     sts,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [19:0]  cfg_wdata,
  input  logic [115:0] item,
  output logic [16:0]  torque_command,
  output logic [18:0]  pressure_target_used
);

  logic [15:0] vp_r, vi_r, pp_r, pi_r, poslim_r, neglim_r;
  logic [19:0] vlim_r;
  logic [17:0] plim_r;
  logic signed [SumW-1:0] vsum_r, psum_r;
  logic        vmode_r, velneg_r;
  logic signed [20:0] vset_r, vmeas_r;
  logic [17:0] peep_r, pmeas_r;
  logic signed [18:0] ptgt_r;
  logic signed [22:0] err_r;
  logic signed [39:0] prod_p_r;
  logic signed [64:0] prod_i_r;
  logic [QuoW-1:0] qhi_r;
  logic signed [16:0] torque_r;

  logic            dstart, dbusy;
  logic [DivW-1:0] dvd;
  logic [15:0]     dvs;
  logic [QuoW-1:0] quo;

  cvp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dvd), .divisor(dvs),
    .busy(dbusy), .quotient(quo)
  );

  // divider operand select
  always_comb begin
    dstart = 1'b0;
    dvd = '0;
    dvs = pi_r;
    unique case (cmd.op)
      OP_VDIV: begin
        dstart = 1'b1; dvs = vi_r; dvd = DivW'({plim_r, 12'd0});
      end
      OP_PDIVH: begin
        dstart = 1'b1; dvd = DivW'({poslim_r, 16'd0});
      end
      OP_PDIVL: begin
        dstart = 1'b1; dvd = DivW'({neglim_r, 16'd0});
      end
      default: ;
    endcase
  end

  logic signed [20:0] vt;
  logic signed [SumW-1:0] vs_add, smax, smin, vs_new, ps_new;
  logic signed [64:0] rsum, rclamp;
  logic signed [39:0] pdiv;
  logic signed [64:0] idiv;
  logic signed [18:0] pt;
  logic signed [16:0] lo;

  always_comb begin
    // volume target clamp, upper bound first
    if (vset_r > $signed({1'b0, vlim_r})) vt = $signed({1'b0, vlim_r});
    else if (vset_r < 0) vt = '0;
    else vt = vset_r;
    lo = velneg_r ? 17'sd0 : -$signed({1'b0, neglim_r});
    vs_add = vsum_r + SumW'(err_r);
    smax = (vi_r == 0) ? '0 : $signed({14'd0, quo});
    if (vs_add > smax) vs_new = smax;
    else if (vs_add < 0) vs_new = '0;
    else vs_new = vs_add;
    // pressure sum clamp: upper quotient kept, lower one fresh
    ps_new = psum_r + SumW'(err_r);
    smax = (pi_r == 0) ? '0 : $signed({14'd0, qhi_r});
    smin = (pi_r == 0 || velneg_r) ? '0 : -$signed({14'd0, quo});
    if (cmd.op == OP_PSUM) begin
      if (ps_new > smax) ps_new = smax;
      else if (ps_new < smin) ps_new = smin;
    end
    // truncating divisions by powers of two
    if (vmode_r && cmd.op == OP_VOUT) begin
      pdiv = (prod_p_r + (prod_p_r < 0 ? 40'sd15 : 40'sd0)) >>> 4;
      idiv = (prod_i_r + (prod_i_r < 0 ? 65'sd4095 : 65'sd0)) >>> 12;
    end else begin
      pdiv = (prod_p_r + (prod_p_r < 0 ? 40'sd255 : 40'sd0)) >>> 8;
      idiv = (prod_i_r + (prod_i_r < 0 ? 65'sd65535 : 65'sd0)) >>> 16;
    end
    rsum = 65'(pdiv) + idiv;
    rclamp = rsum;
    if (cmd.op == OP_VOUT) begin
      if (rsum > $signed({47'd0, plim_r})) rclamp = $signed({47'd0, plim_r});
      else if (rsum < $signed({47'd0, peep_r})) rclamp = $signed({47'd0, peep_r});
    end else begin
      if (rsum > $signed({49'd0, poslim_r})) rclamp = $signed({49'd0, poslim_r});
      else if (rsum < 65'(lo)) rclamp = 65'(lo);
    end
    if (ptgt_r > $signed({1'b0, plim_r})) pt = $signed({1'b0, plim_r});
    else if (ptgt_r < 0) pt = '0;
    else pt = ptgt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0; vi_r <= '0; pp_r <= '0; pi_r <= '0;
      vlim_r <= '0; plim_r <= '0; poslim_r <= '0; neglim_r <= '0;
      vsum_r <= '0; psum_r <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_VOL_P:   vp_r <= cfg_wdata[15:0];
          REG_VOL_I:   vi_r <= cfg_wdata[15:0];
          REG_PRS_P:   pp_r <= cfg_wdata[15:0];
          REG_PRS_I:   pi_r <= cfg_wdata[15:0];
          REG_VOL_LIM: vlim_r <= cfg_wdata;
          REG_PRS_LIM: plim_r <= cfg_wdata[17:0];
          REG_POS_LIM: poslim_r <= cfg_wdata[15:0];
          REG_NEG_LIM: neglim_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_VSUM) vsum_r <= vs_new;
      if (cmd.op == OP_PSUM) psum_r <= ps_new;
    end
    // operation sequence
    unique case (cmd.op)
      OP_LOAD: begin
        vmode_r  <= item[0];
        vset_r   <= $signed(item[21:1]);
        vmeas_r  <= $signed(item[42:22]);
        peep_r   <= item[60:43];
        pmeas_r  <= item[97:80];
        ptgt_r   <= $signed(item[79:61]);
      end
      OP_VDIV: err_r <= 23'(vt) - 23'(vmeas_r);
      OP_VMUL: begin
        prod_p_r <= $signed({1'b0, vp_r}) * 40'(err_r);
        prod_i_r <= $signed({49'd0, vi_r}) * 65'(vsum_r);
      end
      OP_VOUT: ptgt_r <= 19'(rclamp);
      OP_PTERR: err_r <= 23'(pt) - $signed({5'd0, pmeas_r});
      OP_SAVEHI: qhi_r <= quo;
      OP_PMUL: begin
        prod_p_r <= $signed({1'b0, pp_r}) * 40'(err_r);
        prod_i_r <= $signed({49'd0, pi_r}) * 65'(psum_r);
      end
      OP_POUT: torque_r <= 17'(rclamp);
      default: ;
    endcase
  end

  // velocity sign latched with the item
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) velneg_r <= item[115];
  end

  assign sts.div_busy = dbusy;
  assign sts.vmode = vmode_r;
  assign torque_command = torque_r;
  assign pressure_target_used = ptgt_r;

endmodule

>>> sv/cvp_ctrl.sv
// ----------------------------------------------------------------------------
// cvp_ctrl
// Sequencer that steps the datapath through the PI loops for one item; the volume loop is skipped in pressure mode.
// ----------------------------------------------------------------------------
module cvp_ctrl
  import cvp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  cvp_sts_t sts,
  output cvp_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid
);

  localparam logic [3:0] S_IDLE = 4'd0, S_VDIV = 4'd1, S_VWAIT = 4'd2,
    S_VSUM = 4'd3, S_VMUL = 4'd4, S_VOUT = 4'd5, S_PT = 4'd6,
    S_HDIV = 4'd7, S_HWAIT = 4'd8, S_LDIV = 4'd9, S_LWAIT = 4'd10,
    S_PSUM = 4'd11, S_PMUL = 4'd12, S_POUT = 4'd13, S_DONE = 4'd14;

  logic [3:0] st_r, st_nxt;

  // next state and command
  always_comb begin
    st_nxt = st_r;
    cmd.op = OP_NONE;
    unique case (st_r)
      S_IDLE:  if (in_fire) begin cmd.op = OP_LOAD; st_nxt = S_VDIV; end
      S_VDIV:  if (sts.vmode) begin cmd.op = OP_VDIV; st_nxt = S_VWAIT; end
               else st_nxt = S_PT;
      S_VWAIT: if (!sts.div_busy) st_nxt = S_VSUM;
      S_VSUM:  begin cmd.op = OP_VSUM; st_nxt = S_VMUL; end
      S_VMUL:  begin cmd.op = OP_VMUL; st_nxt = S_VOUT; end
      S_VOUT:  begin cmd.op = OP_VOUT; st_nxt = S_PT; end
      S_PT:    begin cmd.op = OP_PTERR; st_nxt = S_HDIV; end
      S_HDIV:  begin cmd.op = OP_PDIVH; st_nxt = S_HWAIT; end
      S_HWAIT: if (!sts.div_busy) begin cmd.op = OP_SAVEHI; st_nxt = S_LDIV; end
      S_LDIV:  begin cmd.op = OP_PDIVL; st_nxt = S_LWAIT; end
      S_LWAIT: if (!sts.div_busy) st_nxt = S_PSUM;
      S_PSUM:  begin cmd.op = OP_PSUM; st_nxt = S_PMUL; end
      S_PMUL:  begin cmd.op = OP_PMUL; st_nxt = S_POUT; end
      S_POUT:  begin cmd.op = OP_POUT; st_nxt = S_DONE; end
      S_DONE:  if (out_fire) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_DONE);

endmodule

>>> sv/cascaded_volume_pressure_pi.sv
// from acceptance to result an item waits on the bit-serial limit divider,
// used once in the volume loop, which runs in volume mode only, and twice in
// the pressure loop
// one transaction at a time: the next can be accepted in the cycle after the
// result is taken
// synchronous active-low reset clears configuration registers, error sums and control
// ----------------------------------------------------------------------------
// cascaded_volume_pressure_pi
// Cascaded volume/pressure PI controller with anti-windup, top level.
// ----------------------------------------------------------------------------
module cascaded_volume_pressure_pi
  import cvp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [19:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // loop_mode, volume_setpoint, measured_volume, peep_pressure,
  // pressure_setpoint, measured_pressure, measured_velocity, zero pad
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // torque_command, pressure_target_used, zero pad
  output logic [39:0]  out_tdata
);

  cvp_cmd_t    cmd;
  cvp_sts_t    sts;
  logic [16:0] torque;
  logic [18:0] ptu;

  cvp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid & in_tready),
    .out_fire(out_tvalid & out_tready), .sts(sts), .cmd(cmd),
    .in_ready(in_tready), .out_valid(out_tvalid)
  );

  cvp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata), .item(in_tdata[115:0]),
    .torque_command(torque), .pressure_target_used(ptu)
  );

  assign out_tdata = {4'd0, ptu, torque};

endmodule

>>> test/cascaded_volume_pressure_pi_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_volume_pressure_pi_checker
// Monitors the configuration port and both stream channels. For every input
// transaction it predicts the torque command and the pressure target from a
// private copy of the registers and error sums, and compares each result
// transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module cascaded_volume_pressure_pi_checker
  import cvp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [19:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [39:0]  out_tdata,
  output int           fail_count,
  output int           pending,
  output int           results_seen
);

  // mirrored registers
  longint vol_p, vol_i, prs_p, prs_i, vol_lim, prs_lim, pos_lim, neg_lim;
  // error sums
  longint vol_sum, prs_sum;
  // predicted results: torque in [16:0], pressure target in [35:17]
  logic [35:0] torque_queue[$];

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one controller tick
  function automatic logic [35:0] control_tick(logic [119:0] d);
    longint vset, vmeas, peep, pset, pmeas, vel;
    longint lo, hi, ptgt, pt, err, smax, smin, r, tq, vt;
    logic [16:0] tq_bits;
    logic [18:0] pt_bits;
    vset  = $signed(d[21:1]);
    vmeas = $signed(d[42:22]);
    peep  = d[60:43];
    pset  = $signed(d[79:61]);
    pmeas = d[97:80];
    vel   = $signed(d[115:98]);
    hi    = pos_lim;
    lo    = -neg_lim;
    // outer volume loop
    if (d[0]) begin
      vt      = limit_to(vset, 0, vol_lim);
      err     = vt - vmeas;
      smax    = (vol_i == 0) ? 0 : (prs_lim * 4096) / vol_i;
      vol_sum = limit_to(vol_sum + err, 0, smax);
      r       = (vol_p * err) / 16 + (vol_i * vol_sum) / 4096;
      ptgt    = limit_to(r, peep, prs_lim);
    end else begin
      ptgt = pset;
    end
    // inner pressure loop
    pt = limit_to(ptgt, 0, prs_lim);
    if (vel < 0) lo = 0;
    err     = pt - pmeas;
    smax    = (prs_i == 0) ? 0 : (hi * 65536) / prs_i;
    smin    = (prs_i == 0) ? 0 : (lo * 65536) / prs_i;
    prs_sum = limit_to(prs_sum + err, smin, smax);
    r       = (prs_p * err) / 256 + (prs_i * prs_sum) / 65536;
    tq      = limit_to(r, lo, hi);
    tq_bits = tq[16:0];
    pt_bits = ptgt[18:0];
    return {pt_bits, tq_bits};
  endfunction

  assign pending = torque_queue.size();

  always @(posedge clk) begin
    logic [35:0] exp_res;
    if (!rst_n) begin
      vol_p = 0; vol_i = 0; prs_p = 0; prs_i = 0;
      vol_lim = 0; prs_lim = 0; pos_lim = 0; neg_lim = 0;
      vol_sum = 0; prs_sum = 0;
      fail_count = 0;
      results_seen = 0;
      torque_queue.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_VOL_P:   vol_p   = cfg_wdata[15:0];
          REG_VOL_I:   vol_i   = cfg_wdata[15:0];
          REG_PRS_P:   prs_p   = cfg_wdata[15:0];
          REG_PRS_I:   prs_i   = cfg_wdata[15:0];
          REG_VOL_LIM: vol_lim = cfg_wdata[19:0];
          REG_PRS_LIM: prs_lim = cfg_wdata[17:0];
          REG_POS_LIM: pos_lim = cfg_wdata[15:0];
          REG_NEG_LIM: neg_lim = cfg_wdata[15:0];
          default: ;
        endcase
      end
      // input transaction
      if (in_tvalid && in_tready)
        torque_queue.push_back(control_tick(in_tdata));
      // result transaction
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (torque_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t unexpected result %h", $realtime, out_tdata);
        end else begin
          exp_res = torque_queue.pop_front();
          if (out_tdata[16:0] !== exp_res[16:0] || out_tdata[35:17] !== exp_res[35:17]
              || out_tdata[39:36] !== 4'b0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%t mismatch: torque exp %0d got %0d, ptarget exp %0d got %0d",
                       $realtime, $signed(exp_res[16:0]), $signed(out_tdata[16:0]),
                       $signed(exp_res[35:17]), $signed(out_tdata[35:17]));
          end
        end
      end
    end
  end

endmodule

>>> test/cascaded_volume_pressure_pi_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_volume_pressure_pi_tb
// Drives register settings and controller ticks into the PI controller with
// bursty input and a stalling receiver; the checker judges every result.
// ----------------------------------------------------------------------------
module cascaded_volume_pressure_pi_tb;
  import cvp_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = REG_VOL_P;
  logic [19:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // loop_mode, volume_setpoint, measured_volume, peep_pressure,
  // pressure_setpoint, measured_pressure, measured_velocity, zero pad
  logic [119:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // torque_command, pressure_target_used, zero pad
  logic [39:0]  out_tdata;

  int  fail_count, pending, results_seen;
  int  ticks_sent = 0;
  int  burst_left = 0;
  int  stall_phase = 0;
  logic in_taken = 1'b0;

  always #1 clk = ~clk;

  cascaded_volume_pressure_pi u_dut (.*);

  cascaded_volume_pressure_pi_checker u_checker (.*);

  // handshake seen at the last rising edge
  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  // receiver back-pressure: free, light and heavy stall stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_phase <= $urandom_range(0, 2);
    case (stall_phase)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic write_settings(logic [15:0] vp, logic [15:0] vi, logic [15:0] pp,
                                logic [15:0] pi, logic [19:0] vl, logic [17:0] pl,
                                logic [15:0] hl, logic [15:0] nl);
    logic [19:0] vals[8];
    vals = '{vp, vi, pp, pi, vl, pl, hl, nl};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // send one tick, with bursts and gaps between them
  task automatic send_tick(logic vm, logic [20:0] vs, logic [20:0] vmeas, logic [17:0] peep,
                           logic [18:0] ps, logic [17:0] pm, logic [17:0] vel);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, vel, pm, ps, peep, vmeas, vs, vm};
    do @(negedge clk); while (!in_taken);
    ticks_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic random_tick();
    logic [17:0] pm;
    pm = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(0, 4000));
    if ($urandom_range(0, 4) == 0)
      send_tick(1'($urandom), 21'($urandom), 21'($urandom), 18'($urandom),
                19'($urandom), 18'($urandom), 18'($urandom));
    else
      send_tick(1'($urandom), 21'($urandom_range(0, 3000)), 21'($urandom_range(0, 3000)),
                18'($urandom_range(0, 1000)), 19'($urandom_range(0, 5000)), pm,
                18'($urandom));
  endtask

  // let every result arrive, then outlast the divider latency
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: every limit zero
    send_tick(1'b1, 21'd500, 21'd0, 18'd0, 19'd100, 18'd0, 18'd5);
    send_tick(1'b0, 21'd0, 21'd0, 18'd0, -19'sd50, 18'd10, -18'sd1);
    drain();

    // extreme settings and field extremes
    write_settings('1, '1, '1, '1, '1, '1, '1, '1);
    send_tick(1'b1, 21'h0FFFFF, 21'h100000, 18'd0, 19'd0, 18'd0, 18'h1FFFF);
    send_tick(1'b1, 21'h100000, 21'h0FFFFF, 18'h3FFFF, 19'd0, 18'h3FFFF, 18'h20000);
    send_tick(1'b1, 21'h0FFFFF, 21'h100000, 18'h3FFFF, 19'd0, 18'd0, 18'd0);
    send_tick(1'b0, 21'd0, 21'd0, 18'd0, 19'h3FFFF, 18'd0, 18'h1FFFF);
    send_tick(1'b0, 21'd0, 21'd0, 18'd0, 19'h40000, 18'h3FFFF, 18'h20000);
    send_tick(1'b0, 21'd0, 21'd0, 18'd0, 19'h40000, 18'h3FFFF, 18'd1);
    send_tick(1'b0, 21'd0, 21'd0, 18'd0, 19'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    drain();

    // peep above the pressure limit, small gains
    write_settings(16'd40, 16'd3, 16'd300, 16'd900, 20'd2000, 18'd800, 16'd1500, 16'd1200);
    send_tick(1'b1, 21'd1000, 21'd900, 18'd1000, 19'd0, 18'd100, 18'd3);
    send_tick(1'b1, 21'd100, 21'd900, 18'd1000, 19'd0, 18'd100, 18'd3);
    send_tick(1'b1, 21'd3000, 21'd0, 18'd500, 19'd0, 18'd600, -18'sd7);
    send_tick(1'b0, 21'd0, 21'd0, 18'd0, -19'sd300, 18'd200, -18'sd7);
    send_tick(1'b0, 21'd0, 21'd0, 18'd0, 19'd5000, 18'd0, 18'd7);
    drain();

    // zero integral gains
    write_settings(16'd100, 16'd0, 16'd500, 16'd0, 20'd4000, 18'd3000, 16'd2000, 16'd2000);
    for (int i = 0; i < 8; i++) random_tick();
    drain();

    // settings phases: random settings, the last phase with fixed extreme settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        write_settings('1, 16'd1, '1, 16'd1, '1, '1, '1, '1);
      else
        write_settings(16'($urandom_range(0, 800)), 16'($urandom_range(0, 200)),
                       16'($urandom_range(0, 4000)), 16'($urandom_range(0, 20000)),
                       20'($urandom_range(0, 5000)), 18'($urandom_range(0, 6000)),
                       16'($urandom), 16'($urandom));
      for (int i = 0; i < 300; i++) begin
        random_tick();
        // full hold-off half way through a phase
        if (i == 150) drain();
      end
      drain();
    end

    $display("%0d controller ticks sent over 10 register settings, %0d results checked",
             ticks_sent, results_seen);
    $display("covered both loop modes, crossed limits and back-pressure patterns");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
